### rtl/assert_macros.svh
// Assertion macros for the RTL of the console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/tccw_pkg.sv
// Types and constants of the text console character writer.
`timescale 1ns / 1ps

package tccw_pkg;

	// Item function codes
	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Character codes with special handling
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_TAB     = 8'd9;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// Attribute after reset
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		S_CLEAR      = 9'b000000001,
		S_IDLE       = 9'b000000010,
		S_READ       = 9'b000000100,
		S_PUT        = 9'b000001000,
		S_FIX        = 9'b000010000,
		S_CHECK      = 9'b000100000,
		S_SCROLL     = 9'b001000000,
		S_SCROLL_END = 9'b010000000,
		S_SPARE      = 9'b100000000
	} state_t;

endpackage

### rtl/text_console_char_writer_top.sv
// Text console writer: screen memory, cursor, and scroll/clear sequencer.
// Sequence: a read passes through S_READ and returns its result from a register; a put walks S_PUT,
// S_FIX (which repeats while the cursor lies past the current row) and S_CHECK. Each scroll
// sweeps S_SCROLL and S_SCROLL_END, copying one cell per cycle through the single read and
// write port of the screen memory. One item at a time: a new item is taken only once the last is done.
// Reset: async active low; then a clearing pass zeroes the screen, and in_ready first rises
// only after the clearing pass has ended.
`timescale 1ns / 1ps

module text_console_char_writer_top #(
	parameter int COLUMNS      = 80,
	parameter int SCREEN_CELLS = 2000,
	parameter int TAB_SHIFT    = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] cursor,
	output logic [15:0] cell_value,
	output logic        scrolled
);
	import tccw_pkg::*;

	`include "assert_macros.svh"

	localparam int AW       = $clog2(SCREEN_CELLS);
	localparam int CW       = $clog2(SCREEN_CELLS + 2 * COLUMNS + 64);
	localparam int TAB_MASK = (1 << TAB_SHIFT) - 1;

	localparam logic [CW-1:0] COLS_C  = CW'(COLUMNS);
	localparam logic [CW-1:0] CELLS_C = CW'(SCREEN_CELLS);
	localparam logic [CW-1:0] MASK_C  = CW'(TAB_MASK);
	localparam logic [AW-1:0] LAST_C  = AW'(SCREEN_CELLS - 1);

	state_t          state_q;
	logic [AW-1:0]   cnt_q;
	logic [CW-1:0]   cursor_q;
	logic [CW-1:0]   row_q;
	logic [7:0]      attr_q;
	logic [7:0]      ch_q;
	logic            rd_ok_q;
	logic            scrolled_q;

	logic            out_valid_q;
	logic [10:0]     out_cursor_q;
	logic [15:0]     out_value_q;
	logic            out_scrolled_q;

	// Screen memory
	logic [15:0]     mem_q [SCREEN_CELLS];
	logic [15:0]     rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;

	// Write stage
	logic            wr_v_d,  wr_v_s1;
	logic [AW-1:0]   wr_addr_d, wr_addr_s1;
	logic [15:0]     wr_data_d, wr_data_s1;
	logic            use_rd_d, use_rd_s1;

	logic            in_go;
	logic [31:0]     idx_ext;
	logic            idx_ok;
	logic [CW-1:0]   src;
	logic            src_ok;
	logic [CW-1:0]   cur0;
	logic [CW-1:0]   row0;
	logic [31:0]     cur_ext;

	assign in_ready = (state_q == S_IDLE) && !wr_v_s1 && (!out_valid_q || out_ready);
	assign in_go    = in_valid && in_ready;

	assign idx_ext = 32'(cell_index);
	assign idx_ok  = idx_ext < 32'(SCREEN_CELLS);

	// Scroll source cell, one row below the destination
	assign src    = CW'(cnt_q) + COLS_C;
	assign src_ok = src < CELLS_C;

	// Cursor wraps to the origin if ever off screen at put start
	assign cur0 = (cursor_q >= CELLS_C) ? '0 : cursor_q;
	assign row0 = (cursor_q >= CELLS_C) ? '0 : row_q;

	// Read port address select
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = src[AW-1:0];
		if (state_q == S_IDLE && in_go && func == FUNC_READ) begin
			rd_en   = 1'b1;
			rd_addr = idx_ext[AW-1:0];
		end else if (state_q == S_SCROLL) begin
			rd_en = src_ok;
		end
	end

	// Write request for the next cycle
	always_comb begin
		wr_v_d    = 1'b0;
		wr_addr_d = cnt_q;
		wr_data_d = '0;
		use_rd_d  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				wr_v_d = 1'b1;
			end
			S_PUT: begin
				if (ch_q != CHAR_NEWLINE && ch_q != CHAR_TAB) begin
					wr_v_d    = 1'b1;
					wr_addr_d = cur0[AW-1:0];
					wr_data_d = {attr_q, ch_q};
				end
			end
			S_SCROLL: begin
				wr_v_d    = 1'b1;
				wr_data_d = {attr_q, CHAR_SPACE};
				use_rd_d  = src_ok;
			end
			default: begin
			end
		endcase
	end

	// Memory read and write ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_v_s1) begin
			mem_q[wr_addr_s1] <= use_rd_s1 ? rd_data_q : wr_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		use_rd_s1  <= use_rd_d;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	assign cur_ext = 32'(cursor_q);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			cnt_q          <= '0;
			cursor_q       <= '0;
			row_q          <= '0;
			ch_q           <= '0;
			rd_ok_q        <= 1'b0;
			out_valid_q    <= 1'b0;
			out_cursor_q   <= '0;
			out_value_q    <= '0;
			out_scrolled_q <= 1'b0;
			wr_v_s1        <= 1'b0;
			scrolled_q     <= 1'b0;
		end else begin
			wr_v_s1 <= wr_v_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == LAST_C) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_go) begin
						ch_q       <= char_code;
						rd_ok_q    <= idx_ok;
						scrolled_q <= 1'b0;
						state_q    <= (func == FUNC_READ) ? S_READ : S_PUT;
					end
				end
				S_READ: begin
					out_valid_q    <= 1'b1;
					out_cursor_q   <= cur_ext[10:0];
					out_value_q    <= rd_ok_q ? rd_data_q : '0;
					out_scrolled_q <= 1'b0;
					state_q        <= S_IDLE;
				end
				S_PUT: begin
					case (ch_q)
						CHAR_NEWLINE: begin
							cursor_q <= row0 + COLS_C;
							row_q    <= row0 + COLS_C;
						end
						CHAR_TAB: begin
							cursor_q <= (cur0 | MASK_C) + 1'b1;
							row_q    <= row0;
						end
						default: begin
							cursor_q <= cur0 + 1'b1;
							row_q    <= row0;
						end
					endcase
					state_q <= S_FIX;
				end
				// Walk the row base up to the cursor's row
				S_FIX: begin
					if (cursor_q >= row_q + COLS_C) begin
						row_q <= row_q + COLS_C;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cursor_q >= CELLS_C) begin
						cnt_q      <= '0;
						scrolled_q <= 1'b1;
						state_q    <= S_SCROLL;
					end else begin
						out_valid_q    <= 1'b1;
						out_cursor_q   <= cur_ext[10:0];
						out_value_q    <= '0;
						out_scrolled_q <= scrolled_q;
						state_q        <= S_IDLE;
					end
				end
				// One destination cell per cycle
				S_SCROLL: begin
					if (cnt_q == LAST_C) begin
						cnt_q   <= '0;
						state_q <= S_SCROLL_END;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				// Last copy drains; cursor moves up one row
				S_SCROLL_END: begin
					if (cursor_q >= COLS_C) begin
						cursor_q <= cursor_q - COLS_C;
						row_q    <= row_q - COLS_C;
					end else begin
						cursor_q <= '0;
						row_q    <= '0;
					end
					state_q <= S_CHECK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor     = out_cursor_q;
	assign cell_value = out_value_q;
	assign scrolled   = out_scrolled_q;

	// Checks
	`AST_HOLDS(a_cursor_on_screen, clk, arst_n, (state_q == S_IDLE) |-> (cursor_q < CELLS_C), "cursor off screen while idle")
	`AST_HOLDS(a_row_base, clk, arst_n, (state_q == S_IDLE) |-> (row_q <= cursor_q && cursor_q < row_q + COLS_C), "row base out of step with cursor")
	`AST_HOLDS(a_result_source, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == S_READ || $past(state_q) == S_CHECK), "result raised outside a finishing state")
	`AST_NEVER(a_scroll_no_accept, clk, arst_n, (state_q == S_SCROLL || state_q == S_CLEAR) && in_ready, "input taken during a memory sweep")

endmodule
